/* rtl/fpw_pkg.sv */
// ============================================================================
// Four-level page walker package
// Shared types, codes and constants of the four-level page walker.
// ============================================================================
package fpw_pkg;

    localparam int PHYS_ADDR_BITS   = 52;
    localparam int LINEAR_ADDR_BITS = 48;
    localparam int PAGE_SHIFT       = 12;
    localparam int INDEX_BITS       = 9;
    localparam int CFG_INDEX_BITS   = 2;
    localparam int CFG_DATA_BITS    = 52;

    // Physical address mask, table base mask and page offset masks.
    localparam logic [51:0] PHYS_MASK  = 52'((64'(1) << PHYS_ADDR_BITS) - 64'(1));
    localparam logic [51:0] TABLE_MASK = PHYS_MASK & ~52'h0_0000_0000_0fff;
    localparam logic [51:0] MASK_1G    = 52'h0_0000_3fff_ffff;
    localparam logic [51:0] MASK_2M    = 52'h0_0000_001f_ffff;
    localparam logic [51:0] MASK_4K    = 52'h0_0000_0000_0fff;

    // Entry bit positions.
    localparam int ENTRY_PRESENT_BIT   = 0;
    localparam int ENTRY_PAGE_SIZE_BIT = 7;

    // Commands of an input request.
    localparam logic CMD_TRANSLATE = 1'b0;
    localparam logic CMD_ENTRY     = 1'b1;

    // Kinds of a result.
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Status codes.
    localparam logic [2:0] STATUS_MAPPED       = 3'd0;
    localparam logic [2:0] STATUS_MODE_UNSUPP  = 3'd1;
    localparam logic [2:0] STATUS_NP_BASE      = 3'd2;

    // Page sizes.
    localparam logic [1:0] PAGE_4K = 2'd0;
    localparam logic [1:0] PAGE_2M = 2'd1;
    localparam logic [1:0] PAGE_1G = 2'd2;

    // Table levels.
    localparam logic [1:0] LEVEL_PML4 = 2'd0;
    localparam logic [1:0] LEVEL_PDPT = 2'd1;
    localparam logic [1:0] LEVEL_PD   = 2'd2;
    localparam logic [1:0] LEVEL_PT   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROOT_TABLE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_MODE  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FIVE_LEVEL = 2'd2;

    typedef struct packed {
        logic        command;
        logic [47:0] linear_address;
        logic [63:0] table_entry;
    } walk_in_t;

    typedef struct packed {
        logic        kind;
        logic [51:0] read_address;
        logic [51:0] physical_address;
        logic [2:0]  status;
        logic [1:0]  page_size;
    } walk_out_t;

    typedef struct packed {
        logic [51:0] root_table_address;
        logic        long_mode_active;
        logic        five_level_enabled;
    } walk_cfg_t;

    typedef struct packed {
        logic        busy;
        logic [1:0]  level;
        logic [47:0] linear_address;
    } walk_state_t;

endpackage

/* rtl/four_level_page_walker.sv */
// ============================================================================
// Four-level page walker
// Translates a 48-bit linear address with the four-level table walk.
// ============================================================================
// Usage. A request on the item channel either starts a translation
// (command zero, with the linear address) or returns a table entry that
// memory has read (command one). Each request gives at most one result on
// the result channel: a memory read request for the next table entry, or a
// finished translation with its status, physical address and page size.
// An entry that arrives while no walk is running gives no result.
// Both channels accept a request at a clock edge where valid is high and
// stall is low. Configuration is written through the cfg channel, which is
// always ready, and should only change while the walker is idle.
// A request is first held in the input register and its result is then
// loaded into the result register, which drives result_valid. Throughput
// is one request per cycle while the receiver does not stall; the step
// logic is a single level of masking, index selection and compare between
// the two registers.
// When the receiver stalls, the result register holds its result and the
// input register can still take one more request, after which the item
// channel stalls too. Reset clears the walk state, the configuration and
// both register valid flags; no clearing pass is needed.
// ============================================================================
module four_level_page_walker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  fpw_pkg::walk_in_t                   item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output fpw_pkg::walk_out_t                  result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fpw_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [fpw_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    fpw_pkg::walk_cfg_t   cfg;

    // Input register: holds the accepted request until the step logic uses it.
    fpw_pkg::walk_in_t    item_reg;
    logic                 item_full_reg;
    logic                 item_full_next;

    // Walk state carried from one request to the next.
    fpw_pkg::walk_state_t state_reg;
    fpw_pkg::walk_state_t state_next;

    // Result register.
    fpw_pkg::walk_out_t   result_reg;
    fpw_pkg::walk_out_t   step_result;
    logic                 step_present;
    logic                 result_full_reg;
    logic                 result_full_next;

    logic                 accept;
    logic                 advance;

    fpw_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fpw_walk_step u_walk_step
    (
        .item       (item_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .state_next (state_next),
        .present    (step_present),
        .result     (step_result)
    );

    // The held request moves on when the result register is empty or is
    // being emptied in this cycle.
    assign advance    = item_full_reg && (!result_full_reg || !result_stall);
    assign item_stall = item_full_reg && !advance;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        item_full_next = item_full_reg;
        if (accept)
        begin
            item_full_next = 1'b1;
        end
        else if (advance)
        begin
            item_full_next = 1'b0;
        end

        result_full_next = result_full_reg;
        if (advance && step_present)
        begin
            result_full_next = 1'b1;
        end
        else if (result_full_reg && !result_stall)
        begin
            result_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_full_reg   <= 1'b0;
            result_full_reg <= 1'b0;
            state_reg       <= '0;
        end
        else
        begin
            item_full_reg   <= item_full_next;
            result_full_reg <= result_full_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (advance && step_present)
        begin
            result_reg <= step_result;
        end
    end

    assign result_valid = result_full_reg;
    assign result       = result_reg;

    // An idle walker always rests at the top level.
    a_idle_level: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.busy |-> state_reg.level == fpw_pkg::LEVEL_PML4)
        else $error("idle walker not at the top level");

    // The input side stalls only behind a stalled, full result register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_full_reg && result_stall)
        else $error("input stalled without a stalled result");

    // A returned entry with no walk running produces no result.
    a_stray_entry: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !result_full_reg && !state_reg.busy
            && item_reg.command == fpw_pkg::CMD_ENTRY |=> !result_full_reg)
        else $error("result produced for an entry while idle");

    // A produced result is always presented in the next cycle.
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance && step_present |=> result_full_reg)
        else $error("produced result was lost");

    // A translation request always leaves the walker busy or finishes it.
    a_translate_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_reg.command == fpw_pkg::CMD_TRANSLATE |=>
            state_reg.busy == (result_reg.kind == fpw_pkg::KIND_READ))
        else $error("walk state disagrees with the translation result");

endmodule

/* rtl/fpw_cfg_regs.sv */
// ============================================================================
// Four-level page walker configuration registers
// Holds the root table address and the two paging mode bits.
// ============================================================================
module fpw_cfg_regs
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [fpw_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [fpw_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    output fpw_pkg::walk_cfg_t                     cfg
);

    fpw_pkg::walk_cfg_t cfg_reg;
    fpw_pkg::walk_cfg_t cfg_next;

    // Writes are taken in any cycle.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fpw_pkg::CFG_ROOT_TABLE: cfg_next.root_table_address = cfg_data[51:0];
                fpw_pkg::CFG_LONG_MODE:  cfg_next.long_mode_active   = cfg_data[0];
                fpw_pkg::CFG_FIVE_LEVEL: cfg_next.five_level_enabled = cfg_data[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/fpw_walk_step.sv */
// ============================================================================
// Four-level page walker step logic
// Works out the result and the next walk state for one input request.
// ============================================================================
module fpw_walk_step
(
    input  fpw_pkg::walk_in_t     item,
    input  fpw_pkg::walk_cfg_t    cfg,
    input  fpw_pkg::walk_state_t  state,
    output fpw_pkg::walk_state_t  state_next,
    output logic                  present,
    output fpw_pkg::walk_out_t    result
);

    // Nine-bit table index of a linear address at a given level.
    function automatic logic [8:0] level_index(input logic [47:0] la, input logic [1:0] level);
        logic [8:0] idx;
        begin
            case (level)
                fpw_pkg::LEVEL_PML4: idx = la[47:39];
                fpw_pkg::LEVEL_PDPT: idx = la[38:30];
                fpw_pkg::LEVEL_PD:   idx = la[29:21];
                fpw_pkg::LEVEL_PT:   idx = la[20:12];
                default:             idx = la[20:12];
            endcase
            return idx;
        end
    endfunction

    function automatic logic [51:0] entry_address(input logic [51:0] base,
                                                  input logic [47:0] la,
                                                  input logic [1:0] level);
        return (base & fpw_pkg::TABLE_MASK) | {40'd0, level_index(la, level), 3'd0};
    endfunction

    logic [51:0] entry_phys;
    logic [51:0] la_wide;
    logic [1:0]  level_inc;
    logic        entry_present;
    logic        entry_large;

    assign entry_phys    = item.table_entry[51:0] & fpw_pkg::PHYS_MASK;
    assign la_wide       = {4'd0, state.linear_address};
    assign level_inc     = state.level + 2'd1;
    assign entry_present = item.table_entry[fpw_pkg::ENTRY_PRESENT_BIT];
    assign entry_large   = item.table_entry[fpw_pkg::ENTRY_PAGE_SIZE_BIT];

    always_comb
    begin
        state_next = state;
        present    = 1'b0;
        result     = '0;

        if (item.command == fpw_pkg::CMD_TRANSLATE)
        begin
            present = 1'b1;
            if (!cfg.long_mode_active || cfg.five_level_enabled)
            begin
                state_next.busy  = 1'b0;
                state_next.level = fpw_pkg::LEVEL_PML4;
                result.kind      = fpw_pkg::KIND_DONE;
                result.status    = fpw_pkg::STATUS_MODE_UNSUPP;
            end
            else
            begin
                state_next.busy           = 1'b1;
                state_next.level          = fpw_pkg::LEVEL_PML4;
                state_next.linear_address = item.linear_address;
                result.kind               = fpw_pkg::KIND_READ;
                result.read_address       = entry_address(cfg.root_table_address,
                                                          item.linear_address,
                                                          fpw_pkg::LEVEL_PML4);
            end
        end
        else if (state.busy)
        begin
            present = 1'b1;
            if (!entry_present)
            begin
                state_next.busy  = 1'b0;
                state_next.level = fpw_pkg::LEVEL_PML4;
                result.kind      = fpw_pkg::KIND_DONE;
                result.status    = fpw_pkg::STATUS_NP_BASE + {1'b0, state.level};
            end
            else if (state.level == fpw_pkg::LEVEL_PT)
            begin
                state_next.busy         = 1'b0;
                state_next.level        = fpw_pkg::LEVEL_PML4;
                result.kind             = fpw_pkg::KIND_DONE;
                result.page_size        = fpw_pkg::PAGE_4K;
                result.physical_address = (entry_phys & ~fpw_pkg::MASK_4K)
                                        | (la_wide & fpw_pkg::MASK_4K);
            end
            else if (entry_large && state.level == fpw_pkg::LEVEL_PDPT)
            begin
                state_next.busy         = 1'b0;
                state_next.level        = fpw_pkg::LEVEL_PML4;
                result.kind             = fpw_pkg::KIND_DONE;
                result.page_size        = fpw_pkg::PAGE_1G;
                result.physical_address = (entry_phys & ~fpw_pkg::MASK_1G)
                                        | (la_wide & fpw_pkg::MASK_1G);
            end
            else if (entry_large && state.level == fpw_pkg::LEVEL_PD)
            begin
                state_next.busy         = 1'b0;
                state_next.level        = fpw_pkg::LEVEL_PML4;
                result.kind             = fpw_pkg::KIND_DONE;
                result.page_size        = fpw_pkg::PAGE_2M;
                result.physical_address = (entry_phys & ~fpw_pkg::MASK_2M)
                                        | (la_wide & fpw_pkg::MASK_2M);
            end
            else
            begin
                state_next.level    = level_inc;
                result.kind         = fpw_pkg::KIND_READ;
                result.read_address = entry_address(entry_phys, state.linear_address,
                                                    level_inc);
            end
        end
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// Four-level page walker testbench
// Drives translate and table-entry requests into the walker, answers nothing
// itself, and checks every response against the bench's walk model or a set value.
// A directed table covers the extremes, each page size and a missing entry at
// three levels, then randomised walks run under several register settings.
// ============================================================================
module tb;
    import fpw_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 6;
    // Two register stages sit between a request and its response, so waiting
    // this long after the last response lets an ignored entry drain.
    localparam int DRAIN_CYCLES = 4;
    // No correct run goes this long without some handshake: the longest gaps
    // are the random idles and the short drain pauses.
    localparam int STALL_LIMIT  = 1000;
    localparam int IDLE_PERCENT = 29;
    localparam int PHASE_COUNT  = 7;

    // Register index beyond the list: the walker must ignore writes to it.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic                      is_write;
        logic [CFG_INDEX_BITS-1:0] reg_index;
        logic [CFG_DATA_BITS-1:0]  reg_value;
        walk_in_t                  req;
        logic                      typed;
        walk_out_t                 want;
    } stim_row_t;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      item_valid   = 1'b0;
    logic                      item_stall;
    walk_in_t                  item         = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    walk_out_t                 result;
    logic                      cfg_valid    = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

    // Copy of the configuration as the walker should hold it.
    logic [51:0] root_shadow       = '0;
    logic        long_mode_shadow  = 1'b0;
    logic        five_level_shadow = 1'b0;

    // Model of the walk state.
    logic        walk_busy_q    = 1'b0;
    logic [1:0]  walk_level_q   = LEVEL_PML4;
    logic [47:0] walk_address_q = '0;

    walk_out_t   awaited_responses[$];
    stim_row_t   directed_rows[$];
    int unsigned answered_count = 0;
    int unsigned error_count    = 0;
    int unsigned quiet_cycles   = 0;
    bit          no_idle        = 1'b0;

    four_level_page_walker dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Byte offset of the entry for the given level within its table: the
    // nine index bits of the saved linear address, times eight.
    function automatic logic [51:0] entry_offset(input logic [1:0] level);
        logic [8:0] index;
        index = 9'(walk_address_q >> (PAGE_SHIFT + INDEX_BITS * (int'(LEVEL_PT) - int'(level))));
        return {40'd0, index, 3'b000};
    endfunction

    // Advances the walk model by one request. Returns one when the request
    // gives a response, which is then left in resp.
    function automatic bit predict_walk_step(input walk_in_t req, output walk_out_t resp);
        logic [51:0] base;
        logic [51:0] va;
        bit          finished;
        resp = '0;
        if (req.command == CMD_TRANSLATE)
        begin
            // A translate always abandons whatever walk was running.
            walk_level_q = LEVEL_PML4;
            if (!long_mode_shadow || five_level_shadow)
            begin
                walk_busy_q = 1'b0;
                resp.kind   = KIND_DONE;
                resp.status = STATUS_MODE_UNSUPP;
                return 1'b1;
            end
            walk_busy_q         = 1'b1;
            walk_address_q      = req.linear_address;
            resp.kind           = KIND_READ;
            resp.read_address   = (root_shadow & TABLE_MASK) | entry_offset(LEVEL_PML4);
            return 1'b1;
        end
        if (!walk_busy_q)
        begin
            return 1'b0;
        end

        base     = req.table_entry[51:0] & PHYS_MASK;
        va       = 52'(walk_address_q);
        finished = 1'b0;
        if (!req.table_entry[ENTRY_PRESENT_BIT])
        begin
            finished    = 1'b1;
            resp.status = STATUS_NP_BASE + 3'(walk_level_q);
        end
        else
        begin
            // The page-size bit only counts at the PDPT and PD levels.
            case (walk_level_q)
                LEVEL_PDPT:
                begin
                    if (req.table_entry[ENTRY_PAGE_SIZE_BIT])
                    begin
                        finished              = 1'b1;
                        resp.physical_address = (base & ~MASK_1G) | (va & MASK_1G);
                        resp.page_size        = PAGE_1G;
                    end
                end
                LEVEL_PD:
                begin
                    if (req.table_entry[ENTRY_PAGE_SIZE_BIT])
                    begin
                        finished              = 1'b1;
                        resp.physical_address = (base & ~MASK_2M) | (va & MASK_2M);
                        resp.page_size        = PAGE_2M;
                    end
                end
                LEVEL_PT:
                begin
                    finished              = 1'b1;
                    resp.physical_address = (base & ~MASK_4K) | (va & MASK_4K);
                    resp.page_size        = PAGE_4K;
                end
                default:
                begin
                end
            endcase
        end

        if (finished)
        begin
            resp.kind    = KIND_DONE;
            walk_busy_q  = 1'b0;
            walk_level_q = LEVEL_PML4;
        end
        else
        begin
            walk_level_q      = walk_level_q + 2'd1;
            resp.kind         = KIND_READ;
            resp.read_address = (base & TABLE_MASK) | entry_offset(walk_level_q);
        end
        return 1'b1;
    endfunction

    function automatic walk_out_t walk_done(input logic [2:0] status);
        walk_out_t resp;
        resp        = '0;
        resp.kind   = KIND_DONE;
        resp.status = status;
        return resp;
    endfunction

    function automatic void add_write(input logic [CFG_INDEX_BITS-1:0] index,
                                      input logic [CFG_DATA_BITS-1:0] value);
        stim_row_t row;
        row           = '0;
        row.is_write  = 1'b1;
        row.reg_index = index;
        row.reg_value = value;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_request(input logic command, input logic [47:0] address,
                                        input logic [63:0] entry, input logic typed,
                                        input walk_out_t want);
        stim_row_t row;
        row                    = '0;
        row.req.command        = command;
        row.req.linear_address = address;
        row.req.table_entry    = entry;
        row.typed              = typed;
        row.want               = want;
        directed_rows.push_back(row);
    endfunction

    function automatic walk_in_t random_request(input logic command);
        walk_in_t req;
        req.command        = command;
        req.linear_address = 48'({$urandom(), $urandom()});
        req.table_entry    = {$urandom(), $urandom()};
        return req;
    endfunction

    // Offers one request to the walker, holding it until it is taken, and
    // records the response that it should give. Valid is left high on
    // return so that back-to-back requests need no extra assignment.
    task automatic send_request(input walk_in_t req, input logic typed, input walk_out_t want);
        walk_out_t predicted;
        bit        answered;
        while (!no_idle && ($urandom_range(0, 99) < IDLE_PERCENT))
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= req;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        answered = predict_walk_step(req, predicted);
        if (answered)
        begin
            awaited_responses.push_back(typed ? want : predicted);
            answered_count++;
        end
    endtask

    // Stops sending and waits until every response has come back, then a
    // little longer so that an ignored entry cannot still be in flight.
    task automatic wait_for_drain();
        item_valid <= 1'b0;
        while (awaited_responses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes one register; cfg_valid stays high for the caller to lower.
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (index)
            CFG_ROOT_TABLE: root_shadow       = value;
            CFG_LONG_MODE:  long_mode_shadow  = value[0];
            CFG_FIVE_LEVEL: five_level_shadow = value[0];
            default:
            begin
            end
        endcase
    endtask

    // Mostly complete walks with random addresses and entries. A walk is cut
    // short now and then, so that the next translate abandons it, and a few
    // stray entries are mixed in. Half-way through, the sender waits for the
    // walker to empty completely.
    task automatic run_random_walks(input int unsigned target);
        walk_in_t    req;
        int unsigned first_count;
        bit          drained;
        first_count = answered_count;
        drained     = 1'b0;
        while (answered_count - first_count < target)
        begin
            if (!drained && (answered_count - first_count >= target / 2))
            begin
                wait_for_drain();
                drained = 1'b1;
            end
            if ($urandom_range(0, 99) < 5)
            begin
                send_request(random_request(CMD_ENTRY), 1'b0, '0);
            end
            else
            begin
                send_request(random_request(CMD_TRANSLATE), 1'b0, '0);
                while (walk_busy_q && ($urandom_range(0, 99) >= 4))
                begin
                    req = random_request(CMD_ENTRY);
                    req.table_entry[ENTRY_PRESENT_BIT]   = ($urandom_range(0, 99) < 92);
                    req.table_entry[ENTRY_PAGE_SIZE_BIT] = ($urandom_range(0, 99) < 35);
                    send_request(req, 1'b0, '0);
                end
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endtask

    task automatic check_response(input walk_out_t got);
        walk_out_t want;
        if (awaited_responses.size() == 0)
        begin
            $error("response arrived with none outstanding: %h", got);
            error_count++;
        end
        else
        begin
            want = awaited_responses.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("read_address", want.read_address, got.read_address);
            compare_field("physical_address", want.physical_address, got.physical_address);
            compare_field("status", want.status, got.status);
            compare_field("page_size", want.page_size, got.page_size);
        end
    endtask

    // The receiver stalls at random, except during the stretch that runs
    // with no idling on either side.
    always @(posedge clk)
    begin
        result_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // Responses are sampled at the clock edge, so the values seen are those
    // from just before it, whatever order the processes run in.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            check_response(result);
        end
    end

    // Ends the run if nothing at all is accepted for too long.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("four_level_page_walker test failed");
            $finish;
        end
    end

    initial
    begin
        logic [51:0] root_value;
        int unsigned target;

        // Straight after reset long mode is off, so a translate fails at
        // once, and an entry with no walk running is dropped.
        add_request(CMD_TRANSLATE, '1, '0, 1'b1, walk_done(STATUS_MODE_UNSUPP));
        add_request(CMD_ENTRY, '0, '1, 1'b0, '0);

        // Root at its top value; the write to the unused index must change
        // nothing.
        add_write(CFG_ROOT_TABLE, '1);
        add_write(CFG_LONG_MODE, 52'd1);
        add_write(CFG_FIVE_LEVEL, 52'd0);
        add_write(CFG_UNUSED, '1);

        // All-ones address and entries: the page-size bit is ignored at the
        // PML4 level and then maps a 1 GB page at the PDPT level.
        add_request(CMD_TRANSLATE, '1, '0, 1'b1,
                    walk_out_t'{KIND_READ, 52'hF_FFFF_FFFF_FFF8, 52'd0, STATUS_MAPPED, PAGE_4K});
        add_request(CMD_ENTRY, '0, '1, 1'b0, '0);
        add_request(CMD_ENTRY, '0, '1, 1'b0, '0);

        // Not present at PML4, then at PDPT.
        add_request(CMD_TRANSLATE, '0, '0, 1'b0, '0);
        add_request(CMD_ENTRY, '0, '0, 1'b1, walk_done(STATUS_NP_BASE + 3'(LEVEL_PML4)));
        add_request(CMD_TRANSLATE, 48'h8040_2010_0ABC, '0, 1'b0, '0);
        add_request(CMD_ENTRY, '0, 64'h0000_0000_0000_1001, 1'b0, '0);
        add_request(CMD_ENTRY, '0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1,
                    walk_done(STATUS_NP_BASE + 3'(LEVEL_PDPT)));

        // A 2 MB page; entry bits above the physical width must be dropped.
        add_request(CMD_TRANSLATE, 48'h7FBF_DFEF_F543, '0, 1'b0, '0);
        add_request(CMD_ENTRY, '0, 64'h8000_0000_0002_3003, 1'b0, '0);
        add_request(CMD_ENTRY, '0, 64'hFFF0_0000_0004_5F7F, 1'b0, '0);
        add_request(CMD_ENTRY, '0, 64'h000F_FFFF_FFE0_0081, 1'b0, '0);

        // A walk abandoned by a new translate, which then runs to a 4 KB
        // page whose entry carries a page-size bit that must be ignored.
        add_request(CMD_TRANSLATE, 48'h0000_0000_1000, '0, 1'b0, '0);
        add_request(CMD_ENTRY, '0, 64'h1, 1'b0, '0);
        add_request(CMD_TRANSLATE, 48'hFFFF_C000_0FFF, '0, 1'b0, '0);
        add_request(CMD_ENTRY, '0, 64'hFFFF_FFFF_FFFF_F07F, 1'b0, '0);
        add_request(CMD_ENTRY, '0, 64'hFFFF_FFFF_FFFF_F07F, 1'b0, '0);
        add_request(CMD_ENTRY, '0, 64'hFFFF_FFFF_FFFF_F07F, 1'b0, '0);
        add_request(CMD_ENTRY, '0, '1, 1'b0, '0);

        // Not present at the last level.
        add_request(CMD_TRANSLATE, 48'h1234_5678_9ABC, '0, 1'b0, '0);
        add_request(CMD_ENTRY, '0, 64'h1, 1'b0, '0);
        add_request(CMD_ENTRY, '0, 64'h1, 1'b0, '0);
        add_request(CMD_ENTRY, '0, 64'h1, 1'b0, '0);
        add_request(CMD_ENTRY, '0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1,
                    walk_done(STATUS_NP_BASE + 3'(LEVEL_PT)));

        // Five-level paging switched on: every translate fails.
        add_write(CFG_FIVE_LEVEL, 52'd1);
        add_request(CMD_TRANSLATE, '1, '0, 1'b1, walk_done(STATUS_MODE_UNSUPP));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_write)
            begin
                if (item_valid)
                begin
                    wait_for_drain();
                end
                write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
            end
            else
            begin
                if (cfg_valid)
                begin
                    cfg_valid <= 1'b0;
                end
                send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Random phases, each with its own settings: the root at zero and at
        // its top value, one phase with long mode off and one with five-level
        // paging on, and one phase with no idling on either side.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            wait_for_drain();
            no_idle = (phase == 2);
            case (phase)
                1:       root_value = '0;
                2:       root_value = '1;
                default: root_value = 52'({$urandom(), $urandom()});
            endcase
            target = (phase == 3 || phase == 4) ? 40 : 210;
            write_register(CFG_ROOT_TABLE, root_value);
            write_register(CFG_LONG_MODE, 52'(phase != 3));
            write_register(CFG_FIVE_LEVEL, 52'(phase == 4));
            cfg_valid <= 1'b0;
            run_random_walks(target);
        end

        wait_for_drain();
        if (error_count == 0)
        begin
            $display("four_level_page_walker test passed");
        end
        else
        begin
            $display("four_level_page_walker test failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/fpw_pkg.sv
rtl/fpw_cfg_regs.sv
rtl/fpw_walk_step.sv
rtl/four_level_page_walker.sv
tb/tb.sv
